// ----- rtl/sltab_pkg.sv -----
package sltab_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // read address select
  localparam logic [2:0] RA_TOP    = 3'd0;
  localparam logic [2:0] RA_POS    = 3'd1;
  localparam logic [2:0] RA_POS_P1 = 3'd2;
  localparam logic [2:0] RA_IDX_M1 = 3'd3;
  localparam logic [2:0] RA_IDX_P2 = 3'd4;

  // write address select
  localparam logic [1:0] WA_ZERO   = 2'd0;
  localparam logic [1:0] WA_IDX    = 2'd1;
  localparam logic [1:0] WA_IDX_P1 = 2'd2;

  typedef struct packed {
    logic       load_op;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       we;
    logic [1:0] wa_sel;
    logic       wd_val;
    logic       idx_top;
    logic       idx_pos;
    logic       idx_dec;
    logic       idx_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       set_full;
    logic       set_range;
    logic       cap_rd;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       cnt_zero;
    logic       pos_oor;
    logic       pos_last;
    logic       gt;
    logic       idx_zero;
    logic       rem_end;
  } dp_stat_t;

endpackage

// ----- rtl/sltab_in_if.sv -----
interface sltab_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] value;
  logic [5:0]         position;

  modport source(output valid, output func, output value, output position, input ready);
  modport sink(input valid, input func, input value, input position, output ready);
endinterface

// ----- rtl/sltab_out_if.sv -----
interface sltab_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [6:0]         entry_count;
  logic [1:0]         status;

  modport source(output valid, output read_value, output entry_count, output status,
                 input ready);
  modport sink(input valid, input read_value, input entry_count, input status,
               output ready);
endinterface

// ----- rtl/sltab_ram.sv -----
module sltab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sltab_dp.sv -----
module sltab_dp import sltab_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_cmd_t                cmd,
  output dp_stat_t                 stat,
  input  logic [1:0]               in_func,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [5:0]               in_position,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [6:0]               out_entry_count,
  output logic [1:0]               out_status
);

  logic [1:0]               func_r;
  logic signed [DATA_W-1:0] val_r;
  logic [5:0]               pos_r;
  logic [ADDR_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         count_m1;
  logic signed [DATA_W-1:0] res_rd_r;
  logic [1:0]               res_st_r;
  logic signed [DATA_W-1:0] out_rd_r;
  logic [6:0]               out_cnt_r;
  logic [1:0]               out_st_r;

  logic [ADDR_W-1:0] raddr, waddr;
  logic [DATA_W-1:0] wdata, rdata;

  assign count_m1 = count_r - CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RA_TOP:    raddr = ADDR_W'(count_m1);
      RA_POS:    raddr = ADDR_W'(pos_r);
      RA_POS_P1: raddr = ADDR_W'(pos_r + 6'd1);
      RA_IDX_M1: raddr = idx_r - ADDR_W'(1);
      RA_IDX_P2: raddr = idx_r + ADDR_W'(2);
      default:   raddr = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.wa_sel)
      WA_ZERO:   waddr = '0;
      WA_IDX:    waddr = idx_r;
      WA_IDX_P1: waddr = idx_r + ADDR_W'(1);
      default:   waddr = idx_r;
    endcase
  end

  assign wdata = cmd.wd_val ? val_r : rdata;

  sltab_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_top) begin
      idx_nxt = ADDR_W'(count_m1);
    end else if (cmd.idx_pos) begin
      idx_nxt = ADDR_W'(pos_r);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - ADDR_W'(1);
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + ADDR_W'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_op) begin
      func_r   <= in_func;
      val_r    <= in_value;
      pos_r    <= in_position;
      res_rd_r <= '0;
      res_st_r <= ST_OK;
    end else begin
      if (cmd.set_full) begin
        res_st_r <= ST_FULL;
      end
      if (cmd.set_range) begin
        res_st_r <= ST_RANGE;
      end
      if (cmd.cap_rd) begin
        res_rd_r <= $signed(rdata);
      end
    end
    if (cmd.out_load) begin
      out_rd_r  <= res_rd_r;
      out_cnt_r <= 7'(count_r);
      out_st_r  <= res_st_r;
    end
  end

  assign stat.func     = func_r;
  assign stat.full     = (count_r == CNT_W'(CAPACITY));
  assign stat.cnt_zero = (count_r == '0);
  assign stat.pos_oor  = (CNT_W'(pos_r) >= count_r);
  assign stat.pos_last = (CNT_W'(pos_r) == count_m1);
  assign stat.gt       = ($signed(rdata) > val_r);
  assign stat.idx_zero = (idx_r == '0);
  // last shift of a remove: idx + 1 is the final valid entry
  assign stat.rem_end  = ((CNT_W'(idx_r) + CNT_W'(2)) == count_r);

  assign out_read_value  = out_rd_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_st_r;

endmodule

// ----- rtl/sltab_ctrl.sv -----
module sltab_ctrl import sltab_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ctrl_cmd_t  cmd,
  input  dp_stat_t   stat
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_INS_LOOP = 3'd2;
  localparam logic [2:0] S_INS_LAST = 3'd3;
  localparam logic [2:0] S_REM_LOOP = 3'd4;
  localparam logic [2:0] S_RD_WAIT  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_DONE;
        case (stat.func)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.set_full = 1'b1;
            end else if (stat.cnt_zero) begin
              cmd.we      = 1'b1;
              cmd.wa_sel  = WA_ZERO;
              cmd.wd_val  = 1'b1;
              cmd.cnt_inc = 1'b1;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = RA_TOP;
              cmd.idx_top = 1'b1;
              state_nxt   = S_INS_LOOP;
            end
          end
          OP_REMOVE: begin
            if (stat.pos_oor) begin
              cmd.set_range = 1'b1;
            end else if (stat.pos_last) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_sel  = RA_POS_P1;
              cmd.idx_pos = 1'b1;
              state_nxt   = S_REM_LOOP;
            end
          end
          OP_READ: begin
            if (stat.pos_oor) begin
              cmd.set_range = 1'b1;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_POS;
              state_nxt  = S_RD_WAIT;
            end
          end
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
            cmd.cnt_clr = 1'b1;
          end
        endcase
      end
      S_INS_LOOP: begin
        // walk down from the top, shifting larger entries up by one
        cmd.we     = 1'b1;
        cmd.wa_sel = WA_IDX_P1;
        if (stat.gt) begin
          if (stat.idx_zero) begin
            state_nxt = S_INS_LAST;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RA_IDX_M1;
            cmd.idx_dec = 1'b1;
          end
        end else begin
          cmd.wd_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_INS_LAST: begin
        cmd.we      = 1'b1;
        cmd.wa_sel  = WA_ZERO;
        cmd.wd_val  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_REM_LOOP: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = WA_IDX;
        if (stat.rem_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RA_IDX_P2;
          cmd.idx_inc = 1'b1;
        end
      end
      S_RD_WAIT: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/sorted_list_table_top.sv -----
// clear, rejected ops and an insert into an empty table finish in dispatch; a read waits
// for the ram; an insert shifts the entries above the value up, a remove shifts the entries
// after position down; the two-port entry ram moves one entry per cycle
// throughput: one transaction at a time, next accepted the cycle after the result
// is registered; results wait in an output register
// reset: synchronous active-low rst_n empties the table, no clearing pass
module sorted_list_table_top import sltab_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sltab_in_if.sink    in_ch,
  sltab_out_if.source out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sltab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sltab_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_ch.func),
    .in_value        (in_ch.value),
    .in_position     (in_ch.position),
    .out_read_value  (out_ch.read_value),
    .out_entry_count (out_ch.entry_count),
    .out_status      (out_ch.status)
  );

endmodule

// ----- sim/sltab_tb_pkg.sv -----
package sltab_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import sltab_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [6:0]               entry_count;
    logic [1:0]               status;
  } reply_t;

  // keeps a copy of the sorted table and the replies still owed by the block
  class table_mirror;
    logic signed [DATA_W-1:0] slots [CAPACITY];
    int                       fill;
    reply_t                   pending_replies [$];
    int                       mismatch_count;

    function new();
      fill           = 0;
      mismatch_count = 0;
    endfunction

    function void note_request(logic [1:0] func, logic signed [DATA_W-1:0] value,
                               logic [5:0] position);
      reply_t r;
      int     at;
      r.read_value = '0;
      r.status     = ST_OK;
      case (func)
        OP_INSERT: begin
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            // new value goes after every entry less than or equal to it
            at = 0;
            while (at < fill && slots[at] <= value) at++;
            for (int i = fill; i > at; i--) slots[i] = slots[i-1];
            slots[at] = value;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (position >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = position; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
        OP_READ: begin
          if (position >= fill) r.status = ST_RANGE;
          else r.read_value = slots[position];
        end
        OP_CLEAR: begin
          fill = 0;
        end
        default: begin
          fill = 0;
        end
      endcase
      r.entry_count = 7'(fill);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic signed [DATA_W-1:0] read_value, logic [6:0] entry_count,
                              logic [1:0] status);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction value=%0d count=%0d status=%0d",
                 $time, read_value, entry_count, status);
        return;
      end
      want = pending_replies.pop_front();
      if (read_value !== want.read_value || entry_count !== want.entry_count ||
          status !== want.status) begin
        mismatch_count++;
        $display("%0t: mismatch expected value=%0d count=%0d status=%0d,",
                 $time, want.read_value, want.entry_count, want.status,
                 " actual value=%0d count=%0d status=%0d",
                 read_value, entry_count, status);
      end
    endfunction
  endclass

endpackage

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sltab_pkg::*;
  import sltab_tb_pkg::*;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int          tx_gap_pct;
  int          rx_stall_pct;
  table_mirror mirror;

  sltab_in_if  in_ch();
  sltab_out_if out_ch();

  sorted_list_table_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // result side: random back-pressure, check every accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        mirror.check_reply(out_ch.read_value, out_ch.entry_count, out_ch.status);
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_op(logic [1:0] func, logic signed [DATA_W-1:0] value,
                         logic [5:0] position);
    int gap = 0;
    while ($urandom_range(99) < tx_gap_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= func;
    in_ch.value    <= value;
    in_ch.position <= position;
    do @(posedge clk); while (!in_ch.ready);
    mirror.note_request(func, value, position);
  endtask

  task automatic random_op(int insert_pct, int remove_pct);
    int                       pick;
    logic [1:0]               func;
    logic signed [DATA_W-1:0] value;
    logic [5:0]               position;
    pick = $urandom_range(99);
    if (pick < insert_pct) func = OP_INSERT;
    else if (pick < insert_pct + remove_pct) func = OP_REMOVE;
    else if (pick < 99) func = OP_READ;
    else func = OP_CLEAR;
    case ($urandom_range(3))
      0: value = $urandom_range(15) - 8;  // narrow range gives many equal entries
      1: begin
        case ($urandom_range(3))
          0: value = 32'h7fff_ffff;
          1: value = 32'h8000_0000;
          2: value = '0;
          default: value = '1;
        endcase
      end
      default: value = $urandom;
    endcase
    if (mirror.fill > 0 && $urandom_range(9) < 8)
      position = 6'($urandom_range(mirror.fill - 1));
    else position = 6'($urandom_range(63));
    send_op(func, value, position);
  endtask

  // runs of growing, shrinking and mixed traffic so the table reaches full and empty
  task automatic random_phase(int items);
    int done = 0;
    int run_len;
    int mode;
    while (done < items) begin
      run_len = $urandom_range(30, 120);
      mode    = $urandom_range(2);
      for (int k = 0; k < run_len && done < items; k++) begin
        case (mode)
          0: random_op(80, 10);
          1: random_op(15, 70);
          default: random_op(40, 30);
        endcase
        done++;
      end
    end
  endtask

  initial begin
    mirror         = new();
    tx_gap_pct     = 13;
    rx_stall_pct   = 65;
    in_ch.valid    = 1'b0;
    in_ch.func     = OP_READ;
    in_ch.value    = '0;
    in_ch.position = '0;
    out_ch.ready   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table corner cases
    send_op(OP_CLEAR,  '0, 6'd0);
    send_op(OP_READ,   '0, 6'd0);
    send_op(OP_REMOVE, '0, 6'd0);
    // extremes and equal values
    send_op(OP_INSERT, 32'h0000_0000, 6'd63);
    send_op(OP_INSERT, 32'h7fff_ffff, 6'd0);
    send_op(OP_INSERT, 32'h8000_0000, 6'd0);
    send_op(OP_INSERT, 32'hffff_ffff, 6'd0);
    send_op(OP_INSERT, 32'sd5, 6'd0);
    send_op(OP_INSERT, 32'sd5, 6'd0);
    send_op(OP_INSERT, 32'h8000_0000, 6'd0);
    send_op(OP_READ,   '0, 6'd0);
    send_op(OP_READ,   '0, 6'd6);
    send_op(OP_READ,   '0, 6'd7);
    send_op(OP_READ,   '1, 6'd63);
    // remove at the head, at the tail and in the middle
    send_op(OP_REMOVE, '0, 6'd0);
    send_op(OP_REMOVE, '0, 6'd5);
    send_op(OP_REMOVE, '0, 6'd2);
    send_op(OP_READ,   '0, 6'd1);
    send_op(OP_CLEAR,  '1, 6'd63);
    send_op(OP_READ,   '0, 6'd0);
    send_op(OP_INSERT, 32'sd42, 6'd0);
    send_op(OP_READ,   '0, 6'd0);

    random_phase(583);
    tx_gap_pct   = 65;
    rx_stall_pct = 13;
    random_phase(583);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    random_phase(584);
    in_ch.valid <= 1'b0;

    while (mirror.pending_replies.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mirror.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
